// ===== rtl/gpss_pkg.sv =====
// ----------------------------------------------------------------------------
// gpss_pkg
// Types and fixed constants shared by the grid path signed-sum blocks.
// ----------------------------------------------------------------------------
package gpss_pkg;

	// Field widths of the requests and results
	localparam int VAL_W    = 7;
	localparam int RES_W    = 15;
	localparam int CFG_W    = 8;
	localparam int ROW_W    = 7;
	localparam int MAX_ROWS = 128;
	// Largest per-cell difference |a-b|
	localparam int KMAX     = 127;

	// Register indexes (decoded from paddr[2])
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Per-cell control handed to the shift unit
	typedef struct packed {
		logic [VAL_W-1:0] k;
		logic             use_up;
		logic             use_left;
		logic             seed;
	} cell_ctl_t;

endpackage

// ===== rtl/gpss_if.sv =====
// ----------------------------------------------------------------------------
// gpss_in_if / gpss_out_if
// Valid/ready channels for cell requests and grid results.
// ----------------------------------------------------------------------------
interface gpss_in_if;
	logic       valid;
	logic       ready;
	logic [6:0] first_value;
	logic [6:0] second_value;

	modport source (output valid, output first_value, output second_value, input ready);
	modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface gpss_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] min_imbalance;
	logic        overflow_seen;

	modport source (output valid, output min_imbalance, output overflow_seen, input ready);
	modport sink   (input valid, input min_imbalance, input overflow_seen, output ready);
endinterface

// ===== rtl/gpss_set_store.sv =====
// ----------------------------------------------------------------------------
// gpss_set_store
// Reachable-set memories: one set per column of the previous row, and the
// set of the cell to the left. One registered read and one write per cycle.
// ----------------------------------------------------------------------------
module gpss_set_store #(
	parameter int WORD_BITS = 64,
	parameter int COL_W     = 7,
	parameter int WAW       = 9,
	parameter int MAX_COLS  = 128
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [COL_W-1:0]     rd_col,
	input  logic [WAW-1:0]       rd_word,
	input  logic                 wr_en,
	input  logic [COL_W-1:0]     wr_col,
	input  logic [WAW-1:0]       wr_word,
	input  logic [WORD_BITS-1:0] wr_data,
	output logic [WORD_BITS-1:0] row_rdata,
	output logic [WORD_BITS-1:0] left_rdata
);

	localparam int ROW_DEPTH = MAX_COLS << WAW;
	localparam int AW        = COL_W + WAW;

	logic [WORD_BITS-1:0] row_mem [ROW_DEPTH];
	logic [WORD_BITS-1:0] left_mem [1 << WAW];

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	assign rd_addr = {rd_col, rd_word};
	assign wr_addr = {wr_col, wr_word};

	// Read both sets of the same word
	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_rdata  <= row_mem[rd_addr];
			left_rdata <= left_mem[rd_word];
		end
	end

	// Write the new cell set into both stores
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[wr_addr]  <= wr_data;
			left_mem[wr_word] <= wr_data;
		end
	end

endmodule

// ===== rtl/gpss_shift_unit.sv =====
// ----------------------------------------------------------------------------
// gpss_shift_unit
// Streams the source set word by word through a window register and forms
// each new word as the union of the set shifted up and down by k.
// ----------------------------------------------------------------------------
module gpss_shift_unit
	import gpss_pkg::*;
#(
	parameter int WORD_BITS = 64,
	parameter int OFFSET    = 16384,
	parameter int NWORDS    = 512,
	parameter int LAGW      = 2,
	parameter int WA        = 10,
	parameter int WAW       = 9,
	parameter int BIT_W     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cell_ctl_t            ctl,
	input  logic                 rd_valid,
	input  logic [WA-1:0]        rd_idx,
	input  logic [WORD_BITS-1:0] row_rdata,
	input  logic [WORD_BITS-1:0] left_rdata,
	output logic                 ovf_hit,
	output logic                 busy,
	output logic                 wr_valid,
	output logic [WAW-1:0]       wr_word,
	output logic [WORD_BITS-1:0] wr_data
);

	localparam int SET_BITS  = 2 * OFFSET;
	localparam int WIN_BITS  = (2 * LAGW + 1) * WORD_BITS;
	localparam int SH_W      = $clog2(WIN_BITS);
	localparam int UP_BASE   = LAGW * WORD_BITS;
	localparam int SEED_WORD = OFFSET / WORD_BITS;
	localparam int SEED_BIT  = OFFSET % WORD_BITS;

	logic [WORD_BITS-1:0] src;
	logic [WIN_BITS-1:0]  win_q;
	logic                 valid_s2;
	logic [WA-1:0]        idx_s2;
	logic [WA-1:0]        out_idx;
	logic [BIT_W-1:0]     in_base;
	logic [BIT_W-1:0]     out_base;
	logic [BIT_W-1:0]     k_ext;
	logic [SH_W-1:0]      up_amt;
	logic [SH_W-1:0]      dn_amt;
	logic [WIN_BITS-1:0]  up_all;
	logic [WIN_BITS-1:0]  dn_all;
	logic                 hit_any;

	// Combine the upper, left and seed contributions of one word
	always_comb begin
		src = '0;
		if (rd_idx < WA'(NWORDS)) begin
			if (ctl.use_up)   src = src | row_rdata;
			if (ctl.use_left) src = src | left_rdata;
			if (ctl.seed && rd_idx == WA'(SEED_WORD)) src[SEED_BIT] = 1'b1;
		end
	end

	// Flag source bits that fall out of range on either shift
	assign in_base = BIT_W'(rd_idx) * BIT_W'(WORD_BITS);
	assign k_ext   = BIT_W'(ctl.k);

	always_comb begin
		hit_any = 1'b0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (src[j] && ((in_base + BIT_W'(j) < k_ext) ||
				(in_base + BIT_W'(j) >= BIT_W'(SET_BITS) - k_ext))) begin
				hit_any = 1'b1;
			end
		end
	end

	assign ovf_hit = rd_valid && hit_any;

	// Advance the window one word per source word
	always_ff @(posedge clk) begin
		if (start) begin
			win_q <= '0;
		end else if (rd_valid) begin
			win_q <= {src, win_q[WIN_BITS-1:WORD_BITS]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= rd_valid && !start;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= rd_idx;
	end

	// Form the output word centered LAGW words behind the newest source word
	assign up_amt  = SH_W'(UP_BASE) - SH_W'(ctl.k);
	assign dn_amt  = SH_W'(UP_BASE) + SH_W'(ctl.k);
	assign up_all  = win_q >> up_amt;
	assign dn_all  = win_q >> dn_amt;
	assign out_idx = idx_s2 - WA'(LAGW);
	assign out_base = BIT_W'(out_idx) * BIT_W'(WORD_BITS);

	// Drop bits past the end of the set
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			wr_data[j] = (up_all[j] | dn_all[j]) &&
				(out_base + BIT_W'(j) < BIT_W'(SET_BITS));
		end
	end

	assign wr_valid = valid_s2 && (idx_s2 >= WA'(LAGW));
	assign wr_word  = out_idx[WAW-1:0];
	assign busy     = valid_s2;

endmodule

// ===== rtl/gpss_min_track.sv =====
// ----------------------------------------------------------------------------
// gpss_min_track
// Watches the words of the new set in ascending order and keeps the nearest
// set bit below and at-or-above the zero sum; gives the least |sum|.
// ----------------------------------------------------------------------------
module gpss_min_track #(
	parameter int WORD_BITS = 64,
	parameter int OFFSET    = 16384,
	parameter int WAW       = 9,
	parameter int BIT_W     = 16,
	parameter int BEST_W    = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 in_valid,
	input  logic [WAW-1:0]       in_word,
	input  logic [WORD_BITS-1:0] in_data,
	output logic                 busy,
	output logic [BEST_W-1:0]    best
);

	logic                 valid_s3;
	logic [WAW-1:0]       word_s3;
	logic [WORD_BITS-1:0] data_s3;
	logic [BIT_W-1:0]     base;
	logic                 fnd_b;
	logic                 fnd_a;
	logic [BIT_W-1:0]     cand_b;
	logic [BIT_W-1:0]     cand_a;
	logic                 have_b_q;
	logic                 have_a_q;
	logic [BIT_W-1:0]     below_q;
	logic [BIT_W-1:0]     above_q;
	logic [BIT_W-1:0]     dist_b;
	logic [BIT_W-1:0]     dist_a;
	logic [BIT_W-1:0]     best_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= in_valid && !start;
		end
	end

	always_ff @(posedge clk) begin
		word_s3 <= in_word;
		data_s3 <= in_data;
	end

	assign base = BIT_W'(word_s3) * BIT_W'(WORD_BITS);

	// Highest set bit below zero sum, lowest at or above it
	always_comb begin
		fnd_b  = 1'b0;
		fnd_a  = 1'b0;
		cand_b = '0;
		cand_a = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (data_s3[j] && (base + BIT_W'(j) < BIT_W'(OFFSET))) begin
				fnd_b  = 1'b1;
				cand_b = base + BIT_W'(j);
			end
		end
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (data_s3[j] && (base + BIT_W'(j) >= BIT_W'(OFFSET))) begin
				fnd_a  = 1'b1;
				cand_a = base + BIT_W'(j);
			end
		end
	end

	// Hold the nearest candidates of this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_b_q <= 1'b0;
			have_a_q <= 1'b0;
		end else if (start) begin
			have_b_q <= 1'b0;
			have_a_q <= 1'b0;
		end else if (valid_s3) begin
			if (fnd_b) have_b_q <= 1'b1;
			if (fnd_a) have_a_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && fnd_b) below_q <= cand_b;
		if (valid_s3 && fnd_a && !have_a_q) above_q <= cand_a;
	end

	// Least distance, empty set gives OFFSET
	assign dist_b = BIT_W'(OFFSET) - below_q;
	assign dist_a = above_q - BIT_W'(OFFSET);

	always_comb begin
		best_w = BIT_W'(OFFSET);
		if (have_a_q && dist_a < best_w) best_w = dist_a;
		if (have_b_q && dist_b < best_w) best_w = dist_b;
	end

	assign best = best_w[BEST_W-1:0];
	assign busy = valid_s3;

endmodule

// ===== rtl/grid_path_signed_sum_reachability_core.sv =====
// ----------------------------------------------------------------------------
// grid_path_signed_sum_reachability_core
// Grid path signed-sum reachability over raster-ordered cells.
// ----------------------------------------------------------------------------
// For each cell the set memory is read one word per cycle, then the pipe
// drains. One cell at a time; the result of the last cell sits in an output
// register while the next grid's cells are taken, all but its last cell,
// which waits until that result is taken.
// Reset clears control, counters and the overflow flag; the set memories
// hold no reset value and every entry is written before its value is used.
// ----------------------------------------------------------------------------
module grid_path_signed_sum_reachability_core
	import gpss_pkg::*;
#(
	parameter int MAX_COLS  = 128,
	parameter int OFFSET    = 16384,
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	gpss_in_if.sink     cell_in,
	gpss_out_if.source  result_out
);

	localparam int SET_BITS = 2 * OFFSET;
	localparam int NWORDS   = (SET_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int LAGW     = (KMAX + WORD_BITS - 1) / WORD_BITS;
	localparam int NSTEPS   = NWORDS + LAGW;
	localparam int WA       = $clog2(NSTEPS + 1);
	localparam int WAW      = $clog2(NWORDS);
	localparam int BIT_W    = $clog2((NSTEPS + 1) * WORD_BITS);
	localparam int BEST_W   = $clog2(OFFSET + 1);
	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CMP_W    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

	state_t               state_q;
	state_t               state_d;
	logic [CFG_W-1:0]     rows_q;
	logic [CFG_W-1:0]     cols_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic                 flag_q;
	cell_ctl_t            ctl_q;
	logic [WA-1:0]        rd_idx_q;
	logic                 valid_s1;
	logic [WA-1:0]        idx_s1;
	logic                 out_valid_q;
	logic [RES_W-1:0]     out_min_q;
	logic                 out_ovf_q;

	logic                 cfg_wr;
	logic                 in_fire;
	logic                 out_fire;
	logic [CFG_W-1:0]     rows_eff;
	logic [CMP_W-1:0]     cols_eff;
	logic                 last_cell;
	logic                 col_wrap;
	logic                 rd_issue;
	logic                 rd_en;
	logic [VAL_W-1:0]     diff;
	logic [WORD_BITS-1:0] row_rdata;
	logic [WORD_BITS-1:0] left_rdata;
	logic                 ovf_hit;
	logic                 shift_busy;
	logic                 wr_valid;
	logic [WAW-1:0]       wr_word;
	logic [WORD_BITS-1:0] wr_data;
	logic                 track_busy;
	logic [BEST_W-1:0]    best;
	logic [BEST_W+RES_W-1:0] best_ext;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_COLS) ? {24'b0, cols_q} : {24'b0, rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(1);
			cols_q <= CFG_W'(1);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_COLS) cols_q <= pwdata[CFG_W-1:0];
			else                      rows_q <= pwdata[CFG_W-1:0];
		end
	end

	// Clamp the grid size
	always_comb begin
		rows_eff = rows_q;
		if (rows_q == '0) rows_eff = CFG_W'(1);
		else if (rows_q > CFG_W'(MAX_ROWS)) rows_eff = CFG_W'(MAX_ROWS);
		cols_eff = CMP_W'(cols_q);
		if (cols_q == '0) cols_eff = CMP_W'(1);
		else if (CMP_W'(cols_q) > CMP_W'(MAX_COLS)) cols_eff = CMP_W'(MAX_COLS);
	end

	assign col_wrap  = (CMP_W'(col_q) + CMP_W'(1)) >= cols_eff;
	assign last_cell = ({1'b0, row_q} == rows_eff - CFG_W'(1)) && col_wrap;

	assign in_fire  = cell_in.valid && cell_in.ready;
	assign out_fire = result_out.valid && result_out.ready;
	assign diff     = (cell_in.first_value > cell_in.second_value) ?
		cell_in.first_value - cell_in.second_value :
		cell_in.second_value - cell_in.first_value;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_RUN;
			ST_RUN:    if (rd_idx_q == WA'(NSTEPS - 1)) state_d = ST_DRAIN;
			ST_DRAIN:  if (!valid_s1 && !shift_busy && !track_busy) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		cell_in.ready = 1'b0;
		rd_issue      = 1'b0;
		case (state_q)
			ST_IDLE:   cell_in.ready = !(out_valid_q && last_cell);
			ST_RUN:    rd_issue = 1'b1;
			ST_DRAIN:  rd_issue = 1'b0;
			ST_FINISH: rd_issue = 1'b0;
			default:   rd_issue = 1'b0;
		endcase
	end

	assign rd_en = rd_issue && (rd_idx_q < WA'(NWORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the cell request
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_q.k        <= diff;
			ctl_q.use_up   <= row_q != '0;
			ctl_q.use_left <= col_q != '0;
			ctl_q.seed     <= (row_q == '0) && (col_q == '0);
		end
	end

	// Advance the read index and the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_issue;
			if (in_fire) rd_idx_q <= '0;
			else if (rd_issue) rd_idx_q <= rd_idx_q + WA'(1);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
	end

	// Position counters and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			flag_q <= 1'b0;
		end else if (cfg_wr) begin
			row_q  <= '0;
			col_q  <= '0;
			flag_q <= 1'b0;
		end else if (state_q == ST_FINISH) begin
			if (last_cell) begin
				row_q  <= '0;
				col_q  <= '0;
				flag_q <= 1'b0;
			end else if (col_wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end else if (ovf_hit) begin
			flag_q <= 1'b1;
		end
	end

	// Result register
	assign best_ext = {{RES_W{1'b0}}, best};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && last_cell) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && last_cell) begin
			out_min_q <= best_ext[RES_W-1:0];
			out_ovf_q <= flag_q;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.min_imbalance = out_min_q;
	assign result_out.overflow_seen = out_ovf_q;

	gpss_set_store #(
		.WORD_BITS (WORD_BITS),
		.COL_W     (COL_W),
		.WAW       (WAW),
		.MAX_COLS  (MAX_COLS)
	) u_store (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_col     (col_q),
		.rd_word    (rd_idx_q[WAW-1:0]),
		.wr_en      (wr_valid),
		.wr_col     (col_q),
		.wr_word    (wr_word),
		.wr_data    (wr_data),
		.row_rdata  (row_rdata),
		.left_rdata (left_rdata)
	);

	gpss_shift_unit #(
		.WORD_BITS (WORD_BITS),
		.OFFSET    (OFFSET),
		.NWORDS    (NWORDS),
		.LAGW      (LAGW),
		.WA        (WA),
		.WAW       (WAW),
		.BIT_W     (BIT_W)
	) u_shift (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_fire),
		.ctl        (ctl_q),
		.rd_valid   (valid_s1),
		.rd_idx     (idx_s1),
		.row_rdata  (row_rdata),
		.left_rdata (left_rdata),
		.ovf_hit    (ovf_hit),
		.busy       (shift_busy),
		.wr_valid   (wr_valid),
		.wr_word    (wr_word),
		.wr_data    (wr_data)
	);

	gpss_min_track #(
		.WORD_BITS (WORD_BITS),
		.OFFSET    (OFFSET),
		.WAW       (WAW),
		.BIT_W     (BIT_W),
		.BEST_W    (BEST_W)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.in_valid (wr_valid),
		.in_word  (wr_word),
		.in_data  (wr_data),
		.busy     (track_busy),
		.best     (best)
	);

`ifndef SYNTHESIS
	// A result appears only out of the finish step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	// The read index stays within the sweep
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> rd_idx_q < WA'(NSTEPS))
		else $error("read index past sweep");

	// No set traffic once the block is idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !valid_s1 && !wr_valid && !track_busy)
		else $error("set traffic while idle");

	// The row position stays inside the grid
	a_row_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> {1'b0, row_q} < rows_eff)
		else $error("row counter outside grid");
`endif

endmodule

// ===== tb/grid_path_signed_sum_reachability_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_path_signed_sum_reachability_core_test
// Drives grids of random cells through the core under several grid shapes,
// predicts the least reachable |sum| and the overflow flag per grid with a
// bitset model, and checks every result against it in order.
// ----------------------------------------------------------------------------
module grid_path_signed_sum_reachability_core_test
	import gpss_pkg::*;
();

	localparam int SET_BITS    = 32768;
	localparam int HALF_RANGE  = 16384;
	localparam int COL_LIMIT   = 128;
	localparam int CELL_TARGET = 1150;
	localparam int CELL_CYCLES = 600;
	localparam int IDLE_LIMIT  = 20000;
	localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};
	localparam logic [2:0] ADDR_COLS = {REG_COLS, 2'b00};

	typedef struct {
		bit [RES_W-1:0] imbalance;
		bit             overflow;
	} grid_result_t;

	// Reachable-sum predictor and store of pending grid results
	class grid_sum_scoreboard;
		typedef bit [SET_BITS-1:0] sum_set_t;
		sum_set_t     col_sets[COL_LIMIT];
		sum_set_t     left_set;
		int           rows_reg = 1;
		int           cols_reg = 1;
		int           row_cnt;
		int           col_cnt;
		bit           ovf;
		grid_result_t pending_results[$];
		int           mismatches;

		function void write_reg(logic idx, int val);
			if (idx == REG_ROWS) rows_reg = val & 8'hFF;
			else cols_reg = val & 8'hFF;
			row_cnt = 0;
			col_cnt = 0;
			ovf = 0;
		endfunction

		function void note_cell(int a, int b);
			int k, rows, cols, col, best;
			sum_set_t src, nxt;
			bit last;
			grid_result_t res;
			k = a > b ? a - b : b - a;
			rows = rows_reg == 0 ? 1 : (rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg);
			cols = cols_reg == 0 ? 1 : (cols_reg > COL_LIMIT ? COL_LIMIT : cols_reg);
			if (row_cnt >= rows) row_cnt = 0;
			if (col_cnt >= cols) col_cnt = 0;
			col = col_cnt;
			src = '0;
			if (row_cnt == 0 && col == 0) src[HALF_RANGE] = 1'b1;
			if (row_cnt > 0) src |= col_sets[col];
			if (col > 0) src |= left_set;
			// flag sums pushed past either end of the kept range
			if (k > 0 && ((src >> (SET_BITS - k)) != 0 || (src << (SET_BITS - k)) != 0))
				ovf = 1;
			nxt = (src << k) | (src >> k);
			col_sets[col] = nxt;
			left_set = nxt;
			last = (row_cnt == rows - 1) && (col == cols - 1);
			col_cnt = col + 1;
			if (col_cnt >= cols) begin
				col_cnt = 0;
				row_cnt++;
			end
			if (last) begin
				best = HALF_RANGE;
				for (int s = 0; s < HALF_RANGE; s++) begin
					if (nxt[HALF_RANGE + s] || nxt[HALF_RANGE - s]) begin
						best = s;
						break;
					end
				end
				res.imbalance = best[RES_W-1:0];
				res.overflow = ovf;
				pending_results.push_back(res);
				row_cnt = 0;
				col_cnt = 0;
				ovf = 0;
			end
		endfunction

		function void check(bit [RES_W-1:0] imbalance, bit overflow);
			grid_result_t exp_res;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: imbalance=%0d overflow=%0d",
						imbalance, overflow);
				return;
			end
			exp_res = pending_results.pop_front();
			if (exp_res.imbalance !== imbalance || exp_res.overflow !== overflow) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: imbalance exp %0d got %0d, overflow exp %0d got %0d",
						exp_res.imbalance, imbalance, exp_res.overflow, overflow);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	gpss_in_if  cell_in();
	gpss_out_if result_out();

	grid_sum_scoreboard grid_sb = new();
	int idle_cycles;
	int stall_left;
	int cells_sent;

	grid_path_signed_sum_reachability_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cell_in    (cell_in),
		.result_out (result_out)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// Check results and vary the sink stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_out.valid && result_out.ready)
				grid_sb.check(result_out.min_imbalance, result_out.overflow_seen);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_out.ready <= 1'b0;
			end else begin
				stall_left <= pick_gap();
				result_out.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((cell_in.valid && cell_in.ready) || (result_out.valid && result_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_cell(int a, int b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cell_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_in.valid <= 1'b1;
		cell_in.first_value <= a[6:0];
		cell_in.second_value <= b[6:0];
		@(posedge clk);
		while (!cell_in.ready) @(posedge clk);
		grid_sb.note_cell(a, b);
		cells_sent++;
	endtask

	// Drop valid, wait for every result, then let a cell in flight finish
	task automatic drain();
		cell_in.valid <= 1'b0;
		@(posedge clk);
		while (grid_sb.pending_results.size() != 0) @(posedge clk);
		repeat (CELL_CYCLES) @(posedge clk);
	endtask

	// Setup and access phases, then the bus returns to idle
	task automatic write_reg(logic idx, int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= idx == REG_ROWS ? ADDR_ROWS : ADDR_COLS;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		grid_sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_grid(int rows, int cols);
		drain();
		write_reg(REG_ROWS, rows);
		write_reg(REG_COLS, cols);
	endtask

	initial begin
		int rows, cols, eff, n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cell_in.valid = 1'b0;
		cell_in.first_value = '0;
		cell_in.second_value = '0;
		result_out.ready = 1'b0;
		idle_cycles = 0;
		stall_left = 0;
		cells_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-cell grids at reset shape: extremes of both fields
		send_cell(0, 0);
		send_cell(127, 0);
		send_cell(0, 127);
		send_cell(127, 127);
		send_cell(85, 42);
		send_cell(42, 85);
		// zero registers count as one
		set_grid(0, 0);
		send_cell(100, 3);
		send_cell(3, 100);
		// small grid, full differences
		set_grid(2, 3);
		for (int i = 0; i < 6; i++) send_cell(i[0] ? 127 : 0, i[0] ? 0 : 127);
		// abandon a grid partway, then restart it
		set_grid(3, 2);
		for (int i = 0; i < 4; i++) send_cell(i * 30, 127 - i * 30);
		drain();
		write_reg(REG_COLS, 2);
		for (int i = 0; i < 6; i++) send_cell(i * 20, 5);

		// long paths that run past the kept range
		set_grid(128, 3);
		for (int i = 0; i < 384; i++) begin
			if ($urandom_range(0, 3) != 0) send_cell(127, 0);
			else send_cell($urandom_range(0, 127), $urandom_range(0, 127));
		end
		// widest row, column register above the limit
		set_grid(1, 255);
		for (int i = 0; i < 128; i++) send_cell($urandom_range(0, 127), $urandom_range(0, 127));

		// random small grids, some cut short
		while (cells_sent < CELL_TARGET) begin
			rows = $urandom_range(0, 9) == 0 ? $urandom_range(129, 255) % 6 : $urandom_range(0, 5);
			cols = $urandom_range(0, 9) == 0 ? 255 : $urandom_range(0, 5);
			if (cols == 255) rows = 1;
			set_grid(rows, cols);
			eff = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : (cols > COL_LIMIT ? COL_LIMIT : cols));
			n = eff * $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0) n = n - $urandom_range(1, eff);
			for (int i = 0; i < n; i++) send_cell($urandom_range(0, 127), $urandom_range(0, 127));
		end

		drain();
		if (grid_sb.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gpss_pkg.sv
rtl/gpss_if.sv
rtl/gpss_set_store.sv
rtl/gpss_shift_unit.sv
rtl/gpss_min_track.sv
rtl/grid_path_signed_sum_reachability_core.sv
tb/grid_path_signed_sum_reachability_core_test.sv
